FILE: hdl/gepc_pkg.sv
// Shared constants, types and helpers of the grid escape path counter.
package gepc_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_MOVES = 64;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROWS_W    = $clog2(MAX_ROWS + 1);
    localparam int COLS_W    = $clog2(MAX_COLS + 1);
    localparam int MOVE_W    = $clog2(MAX_MOVES + 1);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = MAX_ROWS << COL_W;

    // Fixed field widths of the ports
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int BUDGET_IN_W = 7;
    localparam int START_IN_W  = 6;
    localparam int DATA_W      = 30;

    localparam logic [DATA_W-1:0] PRIME = DATA_W'(1000000007);

    // Cycles the write pipeline needs to empty at the end of a layer
    localparam int DRAIN_CYCLES = 2;
    localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS = 1'b0,
        CFG_NUM_COLS = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FETCH,
        ST_CAPT,
        ST_DONE
    } seq_state_t;

    typedef enum logic {
        PH_VERT,
        PH_HORZ
    } phase_t;

    // Read addresses for both layer memories and the bank holding the source layer
    typedef struct packed {
        addr_t addr_a;
        addr_t addr_b;
        logic  bank;
    } rd_port_t;

    // One neighbour-pair request travelling with its read
    typedef struct packed {
        logic   valid;
        phase_t phase;
        logic   out_a;
        logic   out_b;
        logic   zero_in;
        logic   bank;
        addr_t  dest;
    } nb_req_t;

    typedef struct packed {
        logic  en;
        logic  bank;
        addr_t addr;
        data_t data;
    } wr_req_t;

    function automatic addr_t cell_addr(input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] col);
        cell_addr = {row, col};
    endfunction

endpackage

FILE: hdl/gepc_if.sv
// Valid/ready channels carrying query words and result words.
interface gepc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [gepc_pkg::BUDGET_IN_W-1:0]      move_budget;
    logic [gepc_pkg::START_IN_W-1:0]       start_row;
    logic [gepc_pkg::START_IN_W-1:0]       start_col;

    modport source (output valid, output move_budget, output start_row, output start_col,
                    input ready);
    modport sink   (input valid, input move_budget, input start_row, input start_col,
                    output ready);
endinterface

interface gepc_out_if;
    logic                             valid;
    logic                             ready;
    logic [gepc_pkg::DATA_W-1:0]      path_count;
    logic                             bad_start;

    modport source (output valid, output path_count, output bad_start, input ready);
    modport sink   (input valid, input path_count, input bad_start, output ready);
endinterface

FILE: hdl/gepc_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module gepc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hdl/gepc_acc.sv
// Neighbour summing pipeline: pairs reduced modulo the prime, then written back.
module gepc_acc (
    input  logic              clk,
    input  logic              rst_n,
    input  gepc_pkg::nb_req_t req,
    input  gepc_pkg::data_t   rd_a,
    input  gepc_pkg::data_t   rd_b,
    output gepc_pkg::wr_req_t wr
);
    import gepc_pkg::*;

    // Both operands below the prime, so one compare and subtract suffices
    function automatic data_t mod_add(input data_t a, input data_t b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME})
        begin
            s = s - {1'b0, PRIME};
        end
        mod_add = s[DATA_W-1:0];
    endfunction

    nb_req_t req_reg;
    data_t   vert_reg;
    data_t   horz_reg;
    logic    s2_valid_reg;
    logic    s2_bank_reg;
    addr_t   s2_cell_reg;
    data_t   val_a;
    data_t   val_b;
    data_t   pair;

    always_comb
    begin
        val_a = req_reg.out_a ? DATA_W'(1) : (req_reg.zero_in ? '0 : rd_a);
        val_b = req_reg.out_b ? DATA_W'(1) : (req_reg.zero_in ? '0 : rd_b);
        pair  = mod_add(val_a, val_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg      <= '0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            req_reg      <= req;
            s2_valid_reg <= req_reg.valid && (req_reg.phase == PH_HORZ);
        end
    end

    // vert_reg still holds this cell's pair while the horizontal sum is written
    always_ff @(posedge clk)
    begin
        if (req_reg.valid)
        begin
            if (req_reg.phase == PH_VERT)
            begin
                vert_reg <= pair;
            end
            else
            begin
                horz_reg    <= pair;
                s2_cell_reg <= req_reg.dest;
                s2_bank_reg <= req_reg.bank;
            end
        end
    end

    always_comb
    begin
        wr.en   = s2_valid_reg;
        wr.bank = s2_bank_reg;
        wr.addr = s2_cell_reg;
        wr.data = mod_add(vert_reg, horz_reg);
    end

endmodule

FILE: hdl/gepc_seq.sv
// Query sequencer: walks layers and cells, issues neighbour reads, returns results.
module gepc_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    gepc_in_if.sink                       query,
    gepc_out_if.source                    result,
    input  logic [gepc_pkg::CFG_W-1:0]    rows_cfg,
    input  logic [gepc_pkg::CFG_W-1:0]    cols_cfg,
    input  gepc_pkg::data_t               rd_a,
    output gepc_pkg::rd_port_t            rd,
    output gepc_pkg::nb_req_t             req
);
    import gepc_pkg::*;

    seq_state_t          state_reg,  state_next;
    logic [MOVE_W-1:0]   budget_reg, budget_next;
    logic [ROW_W-1:0]    srow_reg,   srow_next;
    logic [COL_W-1:0]    scol_reg,   scol_next;
    logic [ROWS_W-1:0]   rows_reg,   rows_next;
    logic [COLS_W-1:0]   cols_reg,   cols_next;
    logic [MOVE_W-1:0]   layer_reg,  layer_next;
    logic [ROW_W-1:0]    row_reg,    row_next;
    logic [COL_W-1:0]    col_reg,    col_next;
    phase_t              phase_reg,  phase_next;
    logic [DRAIN_W-1:0]  drain_reg,  drain_next;
    data_t               res_count_reg, res_count_next;
    logic                res_bad_reg,   res_bad_next;
    logic                out_valid_reg, out_valid_next;
    data_t               out_count_reg, out_count_next;
    logic                out_bad_reg,   out_bad_next;

    logic [ROWS_W-1:0]   rows_eff;
    logic [COLS_W-1:0]   cols_eff;
    logic [MOVE_W-1:0]   budget_eff;
    logic                last_row;
    logic                last_col;

    assign query.ready       = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.path_count = out_count_reg;
    assign result.bad_start  = out_bad_reg;

    always_comb
    begin
        rows_eff   = (int'(rows_cfg) > MAX_ROWS) ? ROWS_W'(MAX_ROWS) : ROWS_W'(rows_cfg);
        cols_eff   = (int'(cols_cfg) > MAX_COLS) ? COLS_W'(MAX_COLS) : COLS_W'(cols_cfg);
        budget_eff = (int'(query.move_budget) > MAX_MOVES) ? MOVE_W'(MAX_MOVES)
                                                           : MOVE_W'(query.move_budget);
        last_row   = (ROWS_W'(row_reg) + 1'b1) == rows_reg;
        last_col   = (COLS_W'(col_reg) + 1'b1) == cols_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        budget_next    = budget_reg;
        srow_next      = srow_reg;
        scol_next      = scol_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        layer_next     = layer_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        phase_next     = phase_reg;
        drain_next     = drain_reg;
        res_count_next = res_count_reg;
        res_bad_next   = res_bad_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_bad_next   = out_bad_reg;

        rd.addr_a   = cell_addr(row_reg, col_reg);
        rd.addr_b   = cell_addr(row_reg, col_reg);
        rd.bank     = ~layer_reg[0];
        req         = '0;
        req.phase   = phase_reg;
        req.zero_in = (layer_reg == MOVE_W'(1));
        req.bank    = layer_reg[0];
        req.dest    = cell_addr(row_reg, col_reg);

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (query.valid)
                begin
                    budget_next = budget_eff;
                    srow_next   = ROW_W'(query.start_row);
                    scol_next   = COL_W'(query.start_col);
                    rows_next   = rows_eff;
                    cols_next   = cols_eff;
                    layer_next  = MOVE_W'(1);
                    row_next    = '0;
                    col_next    = '0;
                    phase_next  = PH_VERT;
                    if ((int'(query.start_row) >= int'(rows_eff)) ||
                        (int'(query.start_col) >= int'(cols_eff)))
                    begin
                        res_count_next = '0;
                        res_bad_next   = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else if (budget_eff == '0)
                    begin
                        res_count_next = '0;
                        res_bad_next   = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                req.valid = 1'b1;
                if (phase_reg == PH_VERT)
                begin
                    rd.addr_a  = cell_addr(row_reg - 1'b1, col_reg);
                    rd.addr_b  = cell_addr(row_reg + 1'b1, col_reg);
                    req.out_a  = (row_reg == '0);
                    req.out_b  = last_row;
                    phase_next = PH_HORZ;
                end
                else
                begin
                    rd.addr_a  = cell_addr(row_reg, col_reg - 1'b1);
                    rd.addr_b  = cell_addr(row_reg, col_reg + 1'b1);
                    req.out_a  = (col_reg == '0);
                    req.out_b  = last_col;
                    phase_next = PH_VERT;
                    if (last_col)
                    begin
                        col_next = '0;
                        if (last_row)
                        begin
                            row_next   = '0;
                            drain_next = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end

            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DRAIN_CYCLES - 1))
                begin
                    if (layer_reg == budget_reg)
                    begin
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        layer_next = layer_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end

            ST_FETCH:
            begin
                rd.addr_a  = cell_addr(srow_reg, scol_reg);
                rd.bank    = budget_reg[0];
                state_next = ST_CAPT;
            end

            ST_CAPT:
            begin
                res_count_next = rd_a;
                res_bad_next   = 1'b0;
                state_next     = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = res_count_reg;
                    out_bad_next   = res_bad_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            layer_reg     <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= PH_VERT;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            layer_reg     <= layer_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        budget_reg    <= budget_next;
        srow_reg      <= srow_next;
        scol_reg      <= scol_next;
        rows_reg      <= rows_next;
        cols_reg      <= cols_next;
        res_count_reg <= res_count_next;
        res_bad_reg   <= res_bad_next;
        out_count_reg <= out_count_next;
        out_bad_reg   <= out_bad_next;
    end

endmodule

FILE: hdl/grid_escape_path_counter.sv
// Top level of the grid escape path counter: configuration, layer memories and wiring.
//
// Each query word (move_budget, start_row, start_col) yields one result word holding the
// number of up/down/left/right walks of at most move_budget moves that leave the
// num_rows by num_cols grid, modulo 1000000007; bad_start is set, with a count of zero,
// when the start cell lies outside the grid. Grid sizes above 64 and budgets above 64
// saturate to 64. The counts of one move layer live in one of two ping-pong memories of
// 64 x 64 entries; the next layer is built in the other. Each cell's four neighbours are
// fetched in two pairs over the two read ports of the source memory, and each layer ends
// with a drain while the last writes land. Once the last layer is built, a query whose
// start is inside the grid has the start cell's count fetched from it and handed to the
// output register; a bad start or a zero budget goes straight to that hand-over. There
// is no clearing pass: the first layer reads every in-grid neighbour as zero. A query is
// taken only when the previous one has been handed to the output register, which holds
// its result word until the sink takes it. Write num_rows and num_cols only while no
// query is in flight.
module grid_escape_path_counter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gepc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gepc_pkg::CFG_W-1:0]    cfg_data,
    gepc_in_if.sink                       query,
    gepc_out_if.source                    result
);
    import gepc_pkg::*;

    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;
    logic             rd_bank_reg;

    rd_port_t rd;
    nb_req_t  req;
    wr_req_t  wr;
    data_t    r0_a, r0_b, r1_a, r1_b;
    data_t    rd_a, rd_b;

    // Configuration registers, both reset to a single-cell grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_W'(1);
            num_cols_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NUM_ROWS: num_rows_reg <= cfg_data;
                CFG_NUM_COLS: num_cols_reg <= cfg_data;
                default:      num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    // Hold the bank of the outstanding read so its data is taken from the right memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_bank_reg <= 1'b0;
        end
        else
        begin
            rd_bank_reg <= rd.bank;
        end
    end

    assign rd_a = rd_bank_reg ? r1_a : r0_a;
    assign rd_b = rd_bank_reg ? r1_b : r0_b;

    gepc_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .query    (query),
        .result   (result),
        .rows_cfg (num_rows_reg),
        .cols_cfg (num_cols_reg),
        .rd_a     (rd_a),
        .rd       (rd),
        .req      (req)
    );

    gepc_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .wr    (wr)
    );

    // Even layers are built in bank 0, odd layers in bank 1
    gepc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_layer0 (
        .clk     (clk),
        .we      (wr.en && !wr.bank),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .raddr_a (rd.addr_a),
        .rdata_a (r0_a),
        .raddr_b (rd.addr_b),
        .rdata_b (r0_b)
    );

    gepc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_layer1 (
        .clk     (clk),
        .we      (wr.en && wr.bank),
        .waddr   (wr.addr),
        .wdata   (wr.data),
        .raddr_a (rd.addr_a),
        .rdata_a (r1_a),
        .raddr_b (rd.addr_b),
        .rdata_b (r1_b)
    );

endmodule

FILE: dv/grid_escape_path_counter_tb.sv
// Self-checking testbench for the grid escape path counter: stimulus, prediction and checks.
module grid_escape_path_counter_tb;

    import gepc_pkg::*;

    // Give up after this many cycles in which no word moves on either channel.
    localparam int WATCHDOG_LIMIT = 200000;
    // Quiet cycles after the last result before a register write or the end of the run
    localparam int SETTLE_CYCLES  = 16;
    localparam longint unsigned ESC_MOD = 64'd1000000007;

    typedef struct packed {
        logic [BUDGET_IN_W-1:0] move_budget;
        logic [START_IN_W-1:0]  start_row;
        logic [START_IN_W-1:0]  start_col;
    } query_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] path_count;
        logic              bad_start;
    } result_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gepc_in_if  query_ch ();
    gepc_out_if result_ch ();

    grid_escape_path_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .query     (query_ch),
        .result    (result_ch)
    );

    // Query words waiting for the driver, and the result words predicted for accepted queries
    query_word_t  pending_queries [$];
    result_word_t expected_results [$];

    int unsigned queued_words = 0;
    int unsigned taken_words  = 0;
    int unsigned errors       = 0;

    // Copy of the grid size registers as the block holds them; both reset to one
    logic [CFG_W-1:0] grid_rows = 7'd1;
    logic [CFG_W-1:0] grid_cols = 7'd1;

    // Idling is switched per phase so that some phases run without any gaps at all
    logic idle_on = 1'b1;

    // Set at each rising edge when a query word was taken at that edge
    logic query_fire = 1'b0;

    // Two ping-pong layers of the predictor
    longint unsigned esc_prev [MAX_ROWS][MAX_COLS];
    longint unsigned esc_next [MAX_ROWS][MAX_COLS];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // A neighbour inside the grid gives its count from the previous layer; a step off the
    // grid is one escaping walk.
    function automatic longint unsigned neighbour_count(int r, int c, int rows, int cols);
        if (r < 0 || c < 0 || r >= rows || c >= cols)
            return 1;
        return esc_prev[r][c];
    endfunction

    // Count the walks of at most the budget that leave the grid, layer by layer
    function automatic result_word_t count_escapes(query_word_t q,
                                                   logic [CFG_W-1:0] rows_reg,
                                                   logic [CFG_W-1:0] cols_reg);
        int rows;
        int cols;
        int moves;
        int k;
        int r;
        int c;
        longint unsigned sum;
        result_word_t res;

        // Saturate the grid size and the budget to the maxima of the block
        rows  = (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        cols  = (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
        moves = (int'(q.move_budget) > MAX_MOVES) ? MAX_MOVES : int'(q.move_budget);
        res   = '0;

        // Start outside the grid, an empty grid included: zero count and the flag
        if (int'(q.start_row) >= rows || int'(q.start_col) >= cols)
        begin
            res.bad_start = 1'b1;
            return res;
        end

        for (r = 0; r < MAX_ROWS; r++)
            for (c = 0; c < MAX_COLS; c++)
                esc_prev[r][c] = 0;

        for (k = 1; k <= moves; k++)
        begin
            for (r = 0; r < rows; r++)
                for (c = 0; c < cols; c++)
                begin
                    sum = neighbour_count(r - 1, c, rows, cols)
                        + neighbour_count(r + 1, c, rows, cols)
                        + neighbour_count(r, c - 1, rows, cols)
                        + neighbour_count(r, c + 1, rows, cols);
                    esc_next[r][c] = sum % ESC_MOD;
                end
            for (r = 0; r < rows; r++)
                for (c = 0; c < cols; c++)
                    esc_prev[r][c] = esc_next[r][c];
        end

        res.path_count = DATA_W'(esc_prev[q.start_row][q.start_col]);
        return res;
    endfunction

    // ------------------------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------------------------

    // Length of a gap: mostly none or short, now and then long
    function automatic int idle_length();
        int p;
        if (!idle_on)
            return 0;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 90)
            return $urandom_range(1, 4);
        return $urandom_range(16, 200);
    endfunction

    // ------------------------------------------------------------------------------------
    // Driver: present one query word at a time, changing inputs at the falling edge
    // ------------------------------------------------------------------------------------

    always @(negedge clk or negedge rst_n)
    begin : query_driver
        int query_gap;
        query_word_t word;
        if (!rst_n)
        begin
            query_ch.valid       <= 1'b0;
            query_ch.move_budget <= '0;
            query_ch.start_row   <= '0;
            query_ch.start_col   <= '0;
            query_gap = 0;
        end
        else if (!query_ch.valid || query_fire)
        begin
            // The previous word has gone (or there was none): idle, advance or drop valid
            if (query_gap > 0)
            begin
                query_ch.valid <= 1'b0;
                query_gap--;
            end
            else if (pending_queries.size() != 0)
            begin
                word = pending_queries.pop_front();
                query_ch.move_budget <= word.move_budget;
                query_ch.start_row   <= word.start_row;
                query_ch.start_col   <= word.start_col;
                query_ch.valid       <= 1'b1;
                query_gap = idle_length();
            end
            else
                query_ch.valid <= 1'b0;
        end
    end

    // Stall the result channel in random bursts
    always @(negedge clk or negedge rst_n)
    begin : result_stall_gen
        int result_stall;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            result_stall = 0;
        end
        else
        begin
            if (result_stall == 0 && $urandom_range(0, 3) == 0)
                result_stall = idle_length();
            if (result_stall > 0)
            begin
                result_ch.ready <= 1'b0;
                result_stall--;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------------------
    // Monitor: predict on each accepted query, check each accepted result
    // ------------------------------------------------------------------------------------

    always @(posedge clk)
    begin : channel_monitor
        query_word_t  seen;
        result_word_t want;

        query_fire <= rst_n && query_ch.valid && query_ch.ready;

        if (rst_n && query_ch.valid && query_ch.ready)
        begin
            seen.move_budget = query_ch.move_budget;
            seen.start_row   = query_ch.start_row;
            seen.start_col   = query_ch.start_col;
            expected_results.push_back(count_escapes(seen, grid_rows, grid_cols));
            taken_words++;
        end

        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with none expected: path_count %0d bad_start %0b",
                         $time, result_ch.path_count, result_ch.bad_start);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.path_count !== want.path_count)
                begin
                    $display("%0t: path_count expected %0d actual %0d",
                             $time, want.path_count, result_ch.path_count);
                    errors++;
                end
                if (result_ch.bad_start !== want.bad_start)
                begin
                    $display("%0t: bad_start expected %0b actual %0b",
                             $time, want.bad_start, result_ch.bad_start);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing has moved for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("grid_escape_path_counter verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------------------

    // Hold until every queued word is taken and every result has come, then let the
    // block settle; end on a rising edge so that following updates do not meet the driver
    task automatic drain_results();
        while (taken_words != queued_words || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Move to a new grid size once the block is idle, and pick the idling of the phase
    task automatic next_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        drain_results();
        idle_on = ($urandom_range(0, 3) != 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NUM_ROWS;
        cfg_data  <= rows;
        @(negedge clk);
        cfg_index <= CFG_NUM_COLS;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        grid_rows = rows;
        grid_cols = cols;
    endtask

    task automatic queue_query(input int budget, input int row, input int col);
        query_word_t word;
        word.move_budget = BUDGET_IN_W'(budget);
        word.start_row   = START_IN_W'(row);
        word.start_col   = START_IN_W'(col);
        pending_queries.push_back(word);
        queued_words++;
    endtask

    initial
    begin : stimulus
        int ph;
        int n;
        int i;
        int sel;
        int rows_eff;
        int cols_eff;
        int budget;
        int row;
        int col;
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;

        // Drive every input to a known value before the first edge
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_NUM_ROWS;
        cfg_data             = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset grid of one cell: one move escapes four ways, zero moves none, and a
        // start in column one is already off the grid
        queue_query(1, 0, 0);
        queue_query(0, 0, 0);
        queue_query(5, 0, 1);

        // Three by three: zero budget, the centre, a corner, a budget past the maximum,
        // and starts just past the last row and far past the last column
        next_grid(7'd3, 7'd3);
        queue_query(0, 1, 1);
        queue_query(1, 1, 1);
        queue_query(2, 0, 0);
        queue_query(127, 1, 1);
        queue_query(64, 2, 2);
        queue_query(3, 3, 0);
        queue_query(3, 0, 63);

        // No rows: the grid is empty, so every start is outside
        next_grid(7'd0, 7'd5);
        queue_query(4, 0, 0);

        // Rows past the maximum saturate to 64; the last row must be inside
        next_grid(7'd127, 7'd1);
        queue_query(2, 63, 0);
        queue_query(3, 0, 0);

        // Largest grid, with short budgets to keep the run bounded
        next_grid(7'd64, 7'd64);
        queue_query(1, 63, 63);
        queue_query(3, 32, 17);
        queue_query(1, 0, 0);

        // Columns past the maximum, full budget along a single row
        next_grid(7'd1, 7'd127);
        queue_query(64, 0, 63);
        queue_query(100, 0, 31);

        // Counts far past the modulus
        next_grid(7'd8, 7'd8);
        queue_query(64, 3, 4);
        queue_query(127, 0, 0);

        // No rows and no columns, with every input bit clear and with every input bit set
        next_grid(7'd0, 7'd0);
        queue_query(0, 0, 0);
        queue_query(127, 63, 63);

        // Random phases: mostly small grids, some thin ones of any length, a few mid-sized
        for (ph = 0; ph < 10; ph++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 6)
            begin
                rows = CFG_W'($urandom_range(1, 8));
                cols = CFG_W'($urandom_range(1, 8));
            end
            else if (sel < 8)
            begin
                rows = CFG_W'($urandom_range(0, 127));
                cols = CFG_W'($urandom_range(0, 2));
            end
            else if (sel < 9)
            begin
                rows = CFG_W'($urandom_range(0, 2));
                cols = CFG_W'($urandom_range(0, 127));
            end
            else
            begin
                rows = CFG_W'($urandom_range(9, 16));
                cols = CFG_W'($urandom_range(9, 16));
            end
            next_grid(rows, cols);

            rows_eff = (int'(rows) > MAX_ROWS) ? MAX_ROWS : int'(rows);
            cols_eff = (int'(cols) > MAX_COLS) ? MAX_COLS : int'(cols);
            n = $urandom_range(8, 12);
            for (i = 0; i < n; i++)
            begin
                // Keep the budget short on larger grids so that the run stays bounded
                if (rows_eff * cols_eff > 64)
                    budget = $urandom_range(0, 12);
                else
                    budget = $urandom_range(0, 127);
                // Mostly starts inside the grid; the rest anywhere, off the grid included
                if (rows_eff > 0 && cols_eff > 0 && $urandom_range(0, 99) < 85)
                begin
                    row = $urandom_range(0, rows_eff - 1);
                    col = $urandom_range(0, cols_eff - 1);
                end
                else
                begin
                    row = $urandom_range(0, 63);
                    col = $urandom_range(0, 63);
                end
                queue_query(budget, row, col);
            end
        end

        drain_results();
        if (errors == 0)
            $display("grid_escape_path_counter verification clean");
        else
            $display("grid_escape_path_counter verification failed");
        $finish;
    end

endmodule
